@@ rtl/core/bdq_pkg.sv @@
// Package for the bounded deque: sizes, operation codes and status codes.
package bdq_pkg;

  // Store geometry (DEPTH is a power of two so the ring pointers wrap by truncation)
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned PTR_BITS  = $clog2(DEPTH);
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

  // Port field widths
  localparam int unsigned KIND_BITS   = 3;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned FILL_BITS   = 5;

  // Operation codes
  localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_DUP_CHECK  = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_REVERSE    = 3'd5;

  // Status codes
  localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

endpackage

@@ rtl/core/bounded_deque_with_reverse.sv @@
// Bounded double-ended queue with reverse and a scanning duplicate check.
// Push, pop, reverse, unused codes: result next cycle, one item per cycle unless output stalls.
// Duplicate check: one ring read per stored entry through the single read port of the store,
// so the result is registered once the last read has been compared (next cycle when empty).
// Reset (rst_ni low, asynchronous): queue empty, front pointer zero, direction normal,
// no result pending; the ring store itself is not cleared.
module bounded_deque_with_reverse
  import bdq_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [KIND_BITS-1:0]        kind_i,
  input  logic signed [WORD_BITS-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [STATUS_BITS-1:0]      status_o,
  output logic                        has_duplicate_o,
  output logic [FILL_BITS-1:0]        fill_level_o
);

  // Ring store, one write and one registered read port
  logic [WORD_BITS-1:0] ring_mem [DEPTH];
  logic                 mem_we;
  logic [PTR_BITS-1:0]  mem_waddr;
  logic [PTR_BITS-1:0]  mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata_q;

  // Control state
  state_e              state_q, state_d;
  logic [PTR_BITS-1:0] front_q, front_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                rev_q, rev_d;

  // Scan state
  logic [CNT_BITS-1:0]  scan_idx_q, scan_idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [1:0]           hits_q, hits_d;
  logic [WORD_BITS-1:0] key_q, key_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic                   dup_q, dup_d;
  logic [CNT_BITS-1:0]    fill_q, fill_d;

  logic in_xfer;
  logic out_xfer;
  logic phys_front;
  logic scan_issue;
  logic scan_hit;

  assign out_xfer   = out_valid_q & out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) & (~out_valid_q | out_ready_i);
  assign in_xfer    = in_valid_i & in_ready_o;

  // Which physical end the operation touches
  assign phys_front = ((kind_i == KIND_PUSH_FRONT) || (kind_i == KIND_POP_FRONT)) ^ rev_q;

  assign scan_issue = (state_q == ST_SCAN) & (scan_idx_q != count_q);
  assign scan_hit   = rd_vld_q & (mem_rdata_q == key_q);
  assign mem_raddr  = front_q + scan_idx_q[PTR_BITS-1:0];

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    rev_d       = rev_q;
    scan_idx_d  = scan_idx_q;
    rd_vld_d    = scan_issue;
    hits_d      = hits_q;
    key_d       = key_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    status_d    = status_q;
    dup_d       = dup_q;
    fill_d      = fill_q;
    mem_we      = 1'b0;
    mem_waddr   = front_q + count_q[PTR_BITS-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_DONE;
          dup_d       = 1'b0;
          if ((kind_i == KIND_PUSH_FRONT) || (kind_i == KIND_PUSH_BACK)) begin
            if (count_q == CNT_BITS'(DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_BITS'(1);
              if (phys_front) begin
                front_d   = front_q - PTR_BITS'(1);
                mem_waddr = front_q - PTR_BITS'(1);
              end
            end
          end else if ((kind_i == KIND_POP_FRONT) || (kind_i == KIND_POP_BACK)) begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              count_d = count_q - CNT_BITS'(1);
              if (phys_front) begin
                front_d = front_q + PTR_BITS'(1);
              end
            end
          end else if (kind_i == KIND_DUP_CHECK) begin
            // Nonempty store: hold the result and walk the live entries
            if (count_q != '0) begin
              out_valid_d = 1'b0;
              state_d     = ST_SCAN;
              scan_idx_d  = '0;
              hits_d      = '0;
              key_d       = value_i;
            end
          end else if (kind_i == KIND_REVERSE) begin
            rev_d = ~rev_q;
          end
          fill_d = count_d;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          scan_idx_d = scan_idx_q + CNT_BITS'(1);
        end
        // Saturating hit counter, only "more than one" matters
        if (scan_hit && (hits_q != 2'd2)) begin
          hits_d = hits_q + 2'd1;
        end
        // All reads issued and the last compare consumed
        if (!scan_issue && !rd_vld_q) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_DONE;
          dup_d       = (hits_q == 2'd2);
          fill_d      = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    hits_q     <= hits_d;
    key_q      <= key_d;
    status_q   <= status_d;
    dup_q      <= dup_d;
    fill_q     <= fill_d;
  end

  // Ring store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= value_i;
    end
    mem_rdata_q <= ring_mem[mem_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign has_duplicate_o = dup_q;
  assign fill_level_o    = FILL_BITS'(fill_q);

endmodule
